>>> rtl/core/srb_pkg.sv
// Shared types, widths and status codes of the square root bounds unit.
`default_nettype none

package srb_pkg;

  localparam int WORD_BITS   = 64;
  localparam int MUL_CHUNK   = 16;
  localparam int MUL_CHUNKS  = WORD_BITS / MUL_CHUNK;
  localparam int MUL_KW      = $clog2(MUL_CHUNKS);
  localparam int SHIFT_BITS  = $clog2(WORD_BITS);
  localparam int CFG_BITS    = 6;
  localparam int STATUS_BITS = 2;

  localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(8);

  localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_ZERO     = 2'd2;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic  start;
    word_t x;
    word_t y;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    logic  ovf;
    word_t prod;
  } mul_rsp_t;

  typedef struct packed {
    logic  start;
    word_t x;
    word_t y;
  } gcd_req_t;

  typedef struct packed {
    logic  done;
    word_t g;
  } gcd_rsp_t;

  typedef struct packed {
    logic  start;
    word_t n0;
    word_t n1;
    word_t d;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t q0;
    word_t q1;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/srb_if.sv
// Valid/ready channel interfaces for radicand words and bounds words.
`default_nettype none

interface srb_query_if #(
  parameter int RADICAND_BITS = 16
) ();
  logic                     valid;
  logic                     ready;
  logic [RADICAND_BITS-1:0] radicand;

  modport source (output valid, output radicand, input ready);
  modport sink (input valid, input radicand, output ready);
endinterface

interface srb_bounds_if import srb_pkg::*; ();
  logic                   valid;
  logic                   ready;
  word_t                  lower_numerator;
  word_t                  lower_denominator;
  word_t                  upper_numerator;
  word_t                  upper_denominator;
  logic [STATUS_BITS-1:0] status;

  modport source (output valid, output lower_numerator, output lower_denominator,
                  output upper_numerator, output upper_denominator, output status,
                  input ready);
  modport sink (input valid, input lower_numerator, input lower_denominator,
                input upper_numerator, input upper_denominator, input status,
                output ready);
endinterface

`default_nettype wire

>>> rtl/core/srb_mul.sv
// Multi-cycle 64-bit multiplier, 16 multiplier bits a cycle, with overflow flag.
`default_nettype none

module srb_mul import srb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  logic                         busy;
  logic                         done;
  word_t                        xr;
  word_t                        yr;
  word_t                        y_rest;
  logic [MUL_KW-1:0]            k;
  logic [2*WORD_BITS-1:0]       acc;
  logic [2*WORD_BITS-1:0]       addend;
  logic [WORD_BITS+MUL_CHUNK-1:0] part;

  always_comb begin
    part   = xr * yr[MUL_CHUNK-1:0];
    addend = {{(WORD_BITS-MUL_CHUNK){1'b0}}, part} << (MUL_CHUNK * k);
    y_rest = yr >> MUL_CHUNK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (y_rest == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      xr  <= req.x;
      yr  <= req.y;
      acc <= '0;
      k   <= '0;
    end else if (busy) begin
      acc <= acc + addend;
      yr  <= y_rest;
      k   <= k + MUL_KW'(1);
    end
  end

  // Anything above the low word means the product does not fit.
  assign rsp.done = done;
  assign rsp.prod = acc[WORD_BITS-1:0];
  assign rsp.ovf  = |acc[2*WORD_BITS-1:WORD_BITS];

endmodule

`default_nettype wire

>>> rtl/core/srb_gcd.sv
// Binary gcd of two nonzero 64-bit values, one reduction step a cycle.
`default_nettype none

module srb_gcd import srb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire gcd_req_t req,
  output gcd_rsp_t      rsp
);

  logic                  busy;
  logic                  done;
  word_t                 u;
  word_t                 v;
  word_t                 g;
  word_t                 diff;
  word_t                 lesser;
  logic [SHIFT_BITS-1:0] k;
  logic                  u_ge;

  always_comb begin
    u_ge   = (u >= v);
    diff   = u_ge ? (u - v) : (v - u);
    lesser = u_ge ? v : u;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (v == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Common factors of two are counted in k and put back at the end.
  always_ff @(posedge clk) begin
    if (req.start) begin
      u <= req.x;
      v <= req.y;
      k <= '0;
    end else if (busy) begin
      if (v == '0) begin
        g <= u << k;
      end else if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + SHIFT_BITS'(1);
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else begin
        u <= lesser;
        v <= diff >> 1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.g    = g;

endmodule

`default_nettype wire

>>> rtl/core/srb_div.sv
// Restoring divider: two 64-bit dividends over one shared divisor, a bit a cycle.
`default_nettype none

module srb_div import srb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                  busy;
  logic                  done;
  logic [SHIFT_BITS-1:0] cnt;
  word_t                 dr;
  word_t                 a0;
  word_t                 a1;
  word_t                 r0;
  word_t                 r1;
  logic [WORD_BITS:0]    rs0;
  logic [WORD_BITS:0]    rs1;
  logic                  fit0;
  logic                  fit1;

  always_comb begin
    rs0  = {r0, a0[WORD_BITS-1]};
    rs1  = {r1, a1[WORD_BITS-1]};
    fit0 = (rs0 >= {1'b0, dr});
    fit1 = (rs1 >= {1'b0, dr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Dividend registers shift out their top bit and take in quotient bits.
  always_ff @(posedge clk) begin
    if (req.start) begin
      a0  <= req.n0;
      a1  <= req.n1;
      dr  <= req.d;
      r0  <= '0;
      r1  <= '0;
      cnt <= '0;
    end else if (busy) begin
      r0  <= fit0 ? WORD_BITS'(rs0 - {1'b0, dr}) : rs0[WORD_BITS-1:0];
      r1  <= fit1 ? WORD_BITS'(rs1 - {1'b0, dr}) : rs1[WORD_BITS-1:0];
      a0  <= {a0[WORD_BITS-2:0], fit0};
      a1  <= {a1[WORD_BITS-2:0], fit1};
      cnt <= cnt + SHIFT_BITS'(1);
    end
  end

  assign rsp.done = done;
  assign rsp.q0   = a0;
  assign rsp.q1   = a1;

endmodule

`default_nettype wire

>>> rtl/core/sqrt_rational_bounds_unit.sv
// Top level of the square root bounds unit: sequencer, configuration and result register.
`default_nettype none

// For each radicand word N this unit returns rational lower and upper bounds on sqrt(N).
// It first finds a = floor(sqrt(N)) by a bitwise search and r = N - a*a, then runs
// iteration_count refinement steps (saturated to MAX_ITERATIONS) of
// num' = a*(den*a + num) + r*den, den' = den*a + num, reducing each fraction by its gcd
// and filing it as the lower bound when num^2 < N*den^2 and as the upper bound otherwise.
// A bound that is never written reads as zero. A zero radicand returns status 2 with
// zero bounds; a step whose intermediates would not fit in 64 bits stops the run with
// status 1 and leaves the bounds of the step before. All products go through one
// shared 64x16 multiplier (six products per step), gcds through a binary gcd unit (one
// reduction step per cycle) and, only when the gcd is not one, divisions through a
// restoring divider. The input is taken whenever the sequencer is idle, even while the
// previous bounds word still waits in the output register. iteration_count is written
// through cfg_write and cfg_data and must only change while the unit is idle.

module sqrt_rational_bounds_unit import srb_pkg::*; #(
  parameter int RADICAND_BITS  = 16,
  parameter int MAX_ITERATIONS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [CFG_BITS-1:0] cfg_data,
  srb_query_if.sink                query,
  srb_bounds_if.source             bounds
);

  // Root search covers bit positions SQ_TOP down to zero.
  localparam int SQ_TOP = (RADICAND_BITS + 1) / 2;
  localparam int AW     = SQ_TOP + 1;
  localparam int BW     = $clog2(SQ_TOP + 1);
  localparam int SW     = $clog2(MAX_ITERATIONS + 1);

  localparam logic [CFG_BITS:0] MAX_SAT = (CFG_BITS + 1)'(MAX_ITERATIONS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROOT = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_M3   = 4'd4;
  localparam logic [3:0] S_GCD  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_M5   = 4'd7;
  localparam logic [3:0] S_M6   = 4'd8;
  localparam logic [3:0] S_M7   = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [CFG_BITS-1:0] iteration_count;

  logic [3:0]               state, state_next;
  logic [RADICAND_BITS-1:0] n, n_next;
  logic [SW-1:0]            steps, steps_next;
  logic [SW-1:0]            iter, iter_next;
  logic [AW-1:0]            root, root_next;
  logic [RADICAND_BITS-1:0] sq, sq_next;
  logic [BW-1:0]            bit_idx, bit_idx_next;
  logic [AW:0]              rem, rem_next;
  word_t                    num, num_next;
  word_t                    den, den_next;
  word_t                    nn, nn_next;
  word_t                    nd, nd_next;
  word_t                    sq_n, sq_n_next;
  word_t                    lo_n, lo_n_next;
  word_t                    lo_d, lo_d_next;
  word_t                    up_n, up_n_next;
  word_t                    up_d, up_d_next;
  logic [STATUS_BITS-1:0]   status, status_next;
  logic                     out_valid, out_valid_next;
  logic                     load;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  gcd_req_t gcd_req;
  gcd_rsp_t gcd_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [CFG_BITS:0]        sat;
  logic                     take;
  logic [AW-1:0]            cand;
  logic [AW-1:0]            cand_next;
  logic [AW-1:0]            root_upd;
  logic [RADICAND_BITS-1:0] sq_upd;
  logic [WORD_BITS:0]       sum;
  logic [SW-1:0]            iter_inc;
  word_t                    n_word;

  srb_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  srb_gcd u_gcd (.clk(clk), .rst(rst), .req(gcd_req), .rsp(gcd_rsp));
  srb_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_count <= CFG_RESET;
    end else if (cfg_write) begin
      iteration_count <= cfg_data;
    end
  end

  assign query.ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    n_next         = n;
    steps_next     = steps;
    iter_next      = iter;
    root_next      = root;
    sq_next        = sq;
    bit_idx_next   = bit_idx;
    rem_next       = rem;
    num_next       = num;
    den_next       = den;
    nn_next        = nn;
    nd_next        = nd;
    sq_n_next      = sq_n;
    lo_n_next      = lo_n;
    lo_d_next      = lo_d;
    up_n_next      = up_n;
    up_d_next      = up_d;
    status_next    = status;
    load           = 1'b0;
    mul_req        = '0;
    gcd_req        = '0;
    div_req        = '0;

    n_word    = WORD_BITS'(n);
    sat       = ({1'b0, iteration_count} > MAX_SAT) ? MAX_SAT : {1'b0, iteration_count};
    cand      = root | (AW'(1) << bit_idx);
    take      = (mul_rsp.prod <= n_word);
    root_upd  = take ? cand : root;
    sq_upd    = take ? RADICAND_BITS'(mul_rsp.prod) : sq;
    cand_next = root_upd | (AW'(1) << (bit_idx - BW'(1)));
    sum       = {1'b0, mul_rsp.prod} + {1'b0, num};
    iter_inc  = iter + SW'(1);

    case (state)
      S_IDLE: begin
        if (query.valid) begin
          n_next      = query.radicand;
          steps_next  = SW'(sat);
          lo_n_next   = '0;
          lo_d_next   = '0;
          up_n_next   = '0;
          up_d_next   = '0;
          status_next = STATUS_OK;
          if (query.radicand == '0) begin
            status_next = STATUS_ZERO;
            state_next  = S_DONE;
          end else begin
            root_next     = '0;
            sq_next       = '0;
            bit_idx_next  = BW'(SQ_TOP);
            mul_req.start = 1'b1;
            mul_req.x     = WORD_BITS'(AW'(1) << SQ_TOP);
            mul_req.y     = WORD_BITS'(AW'(1) << SQ_TOP);
            state_next    = S_ROOT;
          end
        end
      end

      // One candidate bit of the root per product.
      S_ROOT: begin
        if (mul_rsp.done) begin
          root_next = root_upd;
          sq_next   = sq_upd;
          if (bit_idx == '0) begin
            rem_next  = (AW + 1)'(n - sq_upd);
            num_next  = WORD_BITS'(root_upd);
            den_next  = WORD_BITS'(1);
            iter_next = '0;
            if (steps == '0) begin
              state_next = S_DONE;
            end else begin
              mul_req.start = 1'b1;
              mul_req.x     = WORD_BITS'(1);
              mul_req.y     = WORD_BITS'(root_upd);
              state_next    = S_M1;
            end
          end else begin
            bit_idx_next  = bit_idx - BW'(1);
            mul_req.start = 1'b1;
            mul_req.x     = WORD_BITS'(cand_next);
            mul_req.y     = WORD_BITS'(cand_next);
          end
        end
      end

      // den*a done: form den' = den*a + num, then a*den'.
      S_M1: begin
        if (mul_rsp.done) begin
          if (mul_rsp.ovf || sum[WORD_BITS]) begin
            status_next = STATUS_OVERFLOW;
            state_next  = S_DONE;
          end else begin
            nd_next       = sum[WORD_BITS-1:0];
            mul_req.start = 1'b1;
            mul_req.x     = sum[WORD_BITS-1:0];
            mul_req.y     = WORD_BITS'(root);
            state_next    = S_M2;
          end
        end
      end

      S_M2: begin
        if (mul_rsp.done) begin
          if (mul_rsp.ovf) begin
            status_next = STATUS_OVERFLOW;
            state_next  = S_DONE;
          end else begin
            nn_next       = mul_rsp.prod;
            mul_req.start = 1'b1;
            mul_req.x     = den;
            mul_req.y     = WORD_BITS'(rem);
            state_next    = S_M3;
          end
        end
      end

      // r*den done: num' = a*den' + r*den, then reduce.
      S_M3: begin
        if (mul_rsp.done) begin
          if (mul_rsp.ovf) begin
            status_next = STATUS_OVERFLOW;
            state_next  = S_DONE;
          end else if (({1'b0, nn} + {1'b0, mul_rsp.prod}) > {1'b0, {WORD_BITS{1'b1}}}) begin
            status_next = STATUS_OVERFLOW;
            state_next  = S_DONE;
          end else begin
            nn_next       = nn + mul_rsp.prod;
            gcd_req.start = 1'b1;
            gcd_req.x     = nn + mul_rsp.prod;
            gcd_req.y     = nd;
            state_next    = S_GCD;
          end
        end
      end

      // A gcd of one leaves the fraction as it is and skips the divider.
      S_GCD: begin
        if (gcd_rsp.done) begin
          if (gcd_rsp.g == WORD_BITS'(1)) begin
            mul_req.start = 1'b1;
            mul_req.x     = nn;
            mul_req.y     = nn;
            state_next    = S_M5;
          end else begin
            div_req.start = 1'b1;
            div_req.n0    = nn;
            div_req.n1    = nd;
            div_req.d     = gcd_rsp.g;
            state_next    = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          nn_next       = div_rsp.q0;
          nd_next       = div_rsp.q1;
          mul_req.start = 1'b1;
          mul_req.x     = div_rsp.q0;
          mul_req.y     = div_rsp.q0;
          state_next    = S_M5;
        end
      end

      S_M5: begin
        if (mul_rsp.done) begin
          if (mul_rsp.ovf) begin
            status_next = STATUS_OVERFLOW;
            state_next  = S_DONE;
          end else begin
            sq_n_next     = mul_rsp.prod;
            mul_req.start = 1'b1;
            mul_req.x     = nd;
            mul_req.y     = nd;
            state_next    = S_M6;
          end
        end
      end

      S_M6: begin
        if (mul_rsp.done) begin
          if (mul_rsp.ovf) begin
            status_next = STATUS_OVERFLOW;
            state_next  = S_DONE;
          end else begin
            mul_req.start = 1'b1;
            mul_req.x     = mul_rsp.prod;
            mul_req.y     = n_word;
            state_next    = S_M7;
          end
        end
      end

      // N*den'^2 done: commit the fraction and file it as a bound.
      S_M7: begin
        if (mul_rsp.done) begin
          if (mul_rsp.ovf) begin
            status_next = STATUS_OVERFLOW;
            state_next  = S_DONE;
          end else begin
            num_next  = nn;
            den_next  = nd;
            iter_next = iter_inc;
            if (sq_n < mul_rsp.prod) begin
              lo_n_next = nn;
              lo_d_next = nd;
            end else begin
              up_n_next = nn;
              up_d_next = nd;
            end
            if (iter_inc == steps) begin
              state_next = S_DONE;
            end else begin
              mul_req.start = 1'b1;
              mul_req.x     = nd;
              mul_req.y     = WORD_BITS'(root);
              state_next    = S_M1;
            end
          end
        end
      end

      // Wait here until the output register is free.
      S_DONE: begin
        if (!out_valid || bounds.ready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_next = 1'b1;
    end else if (bounds.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    n       <= n_next;
    steps   <= steps_next;
    iter    <= iter_next;
    root    <= root_next;
    sq      <= sq_next;
    bit_idx <= bit_idx_next;
    rem     <= rem_next;
    num     <= num_next;
    den     <= den_next;
    nn      <= nn_next;
    nd      <= nd_next;
    sq_n    <= sq_n_next;
    lo_n    <= lo_n_next;
    lo_d    <= lo_d_next;
    up_n    <= up_n_next;
    up_d    <= up_d_next;
    status  <= status_next;
    if (load) begin
      bounds.lower_numerator   <= lo_n;
      bounds.lower_denominator <= lo_d;
      bounds.upper_numerator   <= up_n;
      bounds.upper_denominator <= up_d;
      bounds.status            <= status;
    end
  end

  assign bounds.valid = out_valid;

endmodule

`default_nettype wire

>>> verif/tb_sqrt_rational_bounds_unit.sv
// Self-checking testbench for the square root bounds unit with a built-in bounds predictor.
`timescale 1ns / 1ps

module tb_sqrt_rational_bounds_unit;
  import srb_pkg::*;

  localparam int RADICAND_BITS = 16;
  localparam int MAX_STEPS     = 32;

  // The slowest item runs a root search plus 32 steps with full gcd and divider loops, and
  // some 390 items are sent, so this limit is set well above what they all need.
  localparam int CYCLE_LIMIT = 12_000_000;

  // Quiet cycles allowed before a register write and after the last bounds word.
  localparam int SETTLE_CYCLES = 20;
  localparam int TAIL_CYCLES   = 300;

  // Step counts for the phases after the directed one. The last two phases pick theirs
  // at random from the middle of the range.
  localparam int PHASES = 10;
  localparam logic [CFG_BITS-1:0] STEP_PLAN [PHASES] = '{
    6'd0, 6'd1, 6'd32, 6'd63, 6'd2, 6'd8, 6'd33, 6'd31, 6'd4, 6'd16
  };

  typedef struct packed {
    word_t                  lower_numerator;
    word_t                  lower_denominator;
    word_t                  upper_numerator;
    word_t                  upper_denominator;
    logic [STATUS_BITS-1:0] status;
  } bounds_t;

  // One expected bounds word, tagged with the radicand that produced it for reporting.
  typedef struct packed {
    logic [RADICAND_BITS-1:0] radicand;
    bounds_t                  bounds;
  } pending_bounds_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                cfg_write = 1'b0;
  logic [CFG_BITS-1:0] cfg_data  = '0;

  logic                     query_valid    = 1'b0;
  logic [RADICAND_BITS-1:0] query_radicand = '0;
  logic                     bounds_ready   = 1'b0;

  // Local copy of the step count register, as the block sees it.
  logic [CFG_BITS-1:0] step_setting = CFG_RESET;

  // When clear, neither side idles or stalls, so words move back to back.
  bit gaps_on = 1'b1;

  logic [RADICAND_BITS-1:0] radicand_q [$];
  pending_bounds_t          expected_q [$];

  int send_gap    = 0;
  int stall_left  = 0;
  int error_count = 0;
  int cycle_count = 0;

  srb_query_if #(.RADICAND_BITS(RADICAND_BITS)) query_ch ();
  srb_bounds_if bounds_ch ();

  assign query_ch.valid    = query_valid;
  assign query_ch.radicand = query_radicand;
  assign bounds_ch.ready   = bounds_ready;

  sqrt_rational_bounds_unit #(
    .RADICAND_BITS (RADICAND_BITS),
    .MAX_ITERATIONS(MAX_STEPS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .query    (query_ch),
    .bounds   (bounds_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Full 128-bit product, so that the upper half tells whether 64 bits would overflow.
  function automatic logic [127:0] mul_wide(input word_t x, input word_t y);
    return {64'd0, x} * {64'd0, y};
  endfunction

  // Idle lengths: mostly none or a few cycles, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // Computes the bounds word for one radicand under the given step count.
  // The root is found bit by bit, then each step forms the next convergent, reduces it
  // by its gcd and files it as lower or upper bound. Any intermediate that would need
  // more than 64 bits ends the steps with an overflow status and keeps the old bounds.
  function automatic bounds_t predict_bounds(input logic [RADICAND_BITS-1:0] rad,
                                             input logic [CFG_BITS-1:0] setting);
    bounds_t      res;
    word_t        n, a, r, num, den, nn, nd, gx, gy, gt, cand;
    logic [127:0] p_den_a, p_a_sum, p_r_den, p_nn, p_nd, p_rhs;
    logic [64:0]  s_den, s_num;
    int           steps;
    bit           stop;

    res = '0;
    res.status = STATUS_OK;
    n = word_t'(rad);
    steps = (int'(setting) > MAX_STEPS) ? MAX_STEPS : int'(setting);
    a = '0;
    if (n == 0) begin
      res.status = STATUS_ZERO;
      steps = 0;
    end else begin
      for (int b = (RADICAND_BITS + 1) / 2; b >= 0; b--) begin
        cand = a | (word_t'(1) << b);
        if (cand * cand <= n) a = cand;
      end
    end
    r = n - a * a;
    num = a;
    den = 64'd1;
    stop = 1'b0;

    for (int i = 0; i < steps && !stop; i++) begin
      p_den_a = mul_wide(den, a);
      s_den   = {1'b0, p_den_a[63:0]} + {1'b0, num};
      p_a_sum = mul_wide(a, s_den[63:0]);
      p_r_den = mul_wide(r, den);
      s_num   = {1'b0, p_a_sum[63:0]} + {1'b0, p_r_den[63:0]};
      if (p_den_a[127:64] != 0 || s_den[64] || p_a_sum[127:64] != 0 ||
          p_r_den[127:64] != 0 || s_num[64]) begin
        res.status = STATUS_OVERFLOW;
        stop = 1'b1;
      end else begin
        nn = s_num[63:0];
        nd = s_den[63:0];
        gx = nn;
        gy = nd;
        while (gy != 0) begin
          gt = gx % gy;
          gx = gy;
          gy = gt;
        end
        if (gx != 0) begin
          nn = nn / gx;
          nd = nd / gx;
        end
        p_nn  = mul_wide(nn, nn);
        p_nd  = mul_wide(nd, nd);
        p_rhs = mul_wide(n, p_nd[63:0]);
        if (p_nn[127:64] != 0 || p_nd[127:64] != 0 || p_rhs[127:64] != 0) begin
          res.status = STATUS_OVERFLOW;
          stop = 1'b1;
        end else begin
          num = nn;
          den = nd;
          if (p_nn[63:0] < p_rhs[63:0]) begin
            res.lower_numerator   = num;
            res.lower_denominator = den;
          end else begin
            res.upper_numerator   = num;
            res.upper_denominator = den;
          end
        end
      end
    end
    return res;
  endfunction

  // Radicand driver. The gap drawn when a word goes out is spent after it is taken,
  // before the next word is offered. With no gap the valid simply stays high.
  always @(posedge clk) begin
    logic                     next_valid;
    logic [RADICAND_BITS-1:0] next_radicand;
    pending_bounds_t          entry;
    if (rst) begin
      query_valid <= 1'b0;
      send_gap    <= 0;
    end else begin
      next_valid    = query_valid;
      next_radicand = query_radicand;
      if (query_valid && query_ch.ready) begin
        entry.radicand = query_radicand;
        entry.bounds   = predict_bounds(query_radicand, step_setting);
        expected_q.push_back(entry);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (radicand_q.size() != 0) begin
          next_valid    = 1'b1;
          next_radicand = radicand_q.pop_front();
          send_gap      <= pick_gap();
        end
      end
      query_valid    <= next_valid;
      query_radicand <= next_radicand;
    end
  end

  // Bounds monitor. Every accepted word is checked against the oldest expectation,
  // and the ready line stalls after some words and now and then on its own.
  always @(posedge clk) begin
    bounds_t         got;
    pending_bounds_t want;
    bit              taken;
    int              stall;
    if (rst) begin
      bounds_ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      taken = bounds_ch.valid && bounds_ready;
      if (taken) begin
        got.lower_numerator   = bounds_ch.lower_numerator;
        got.lower_denominator = bounds_ch.lower_denominator;
        got.upper_numerator   = bounds_ch.upper_numerator;
        got.upper_denominator = bounds_ch.upper_denominator;
        got.status            = bounds_ch.status;
        if (expected_q.size() == 0) begin
          if (error_count < 10)
            $display("%0d: bounds word with none pending: lo %0d/%0d up %0d/%0d status %0d",
                     cycle_count, got.lower_numerator, got.lower_denominator,
                     got.upper_numerator, got.upper_denominator, got.status);
          error_count = error_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got.lower_numerator   !== want.bounds.lower_numerator ||
              got.lower_denominator !== want.bounds.lower_denominator ||
              got.upper_numerator   !== want.bounds.upper_numerator ||
              got.upper_denominator !== want.bounds.upper_denominator ||
              got.status            !== want.bounds.status) begin
            if (error_count < 10) begin
              $display("%0d: radicand %0d: expected lo %0d/%0d up %0d/%0d status %0d",
                       cycle_count, want.radicand,
                       want.bounds.lower_numerator, want.bounds.lower_denominator,
                       want.bounds.upper_numerator, want.bounds.upper_denominator,
                       want.bounds.status);
              $display("%0d: radicand %0d: actual   lo %0d/%0d up %0d/%0d status %0d",
                       cycle_count, want.radicand,
                       got.lower_numerator, got.lower_denominator,
                       got.upper_numerator, got.upper_denominator, got.status);
            end
            error_count = error_count + 1;
          end
        end
      end
      if (stall_left > 0) begin
        bounds_ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (gaps_on && (taken || $urandom_range(0, 15) == 0)) begin
        stall = pick_gap();
        bounds_ready <= (stall == 0);
        stall_left   <= (stall > 0) ? stall - 1 : 0;
      end else begin
        bounds_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_sqrt_rational_bounds_unit: done, errors");
      $finish;
    end
  end

  // Holds the sender back until every radicand is taken and every bounds word is back.
  // Polled on the falling edge, when all updates of the rising edge have settled.
  task automatic wait_until_idle();
    while (radicand_q.size() != 0 || query_valid || expected_q.size() != 0)
      @(negedge clk);
  endtask

  // Writes the step count register. Only called with the unit idle.
  task automatic write_step_setting(input logic [CFG_BITS-1:0] value);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    step_setting = value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [CFG_BITS-1:0]      setting;
    logic [RADICAND_BITS-1:0] value;
    int                       roll;
    int                       root;
    int                       count;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words under the reset step count: zero radicand, radicand one, small and
    // perfect squares, the largest radicand and the largest square, alternating bit
    // patterns, and large radicands that overflow within the eight steps.
    radicand_q = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd15, 16'd16, 16'd17, 16'd48,
                   16'd99, 16'd255, 16'd256, 16'hFFFF, 16'd65025, 16'd65024, 16'd65026,
                   16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555};

    for (int p = 0; p < PHASES; p++) begin
      // Pausing here until every bounds word is back is also what makes the register
      // write safe.
      wait_until_idle();
      setting = (p >= 8) ? CFG_BITS'($urandom_range(3, 30)) : STEP_PLAN[p];
      write_step_setting(setting);
      gaps_on = (p % 4 != 2);
      count = (setting == 0) ? 12 : 40;
      for (int k = 0; k < count; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          value = RADICAND_BITS'($urandom());
        end else if (roll < 60) begin
          value = RADICAND_BITS'($urandom_range(1, 300));
        end else if (roll < 80) begin
          // Squares and their neighbors; on a square the bounds land exactly on the root.
          root  = $urandom_range(1, 255);
          value = RADICAND_BITS'(root * root + $urandom_range(0, 2) - 1);
        end else if (roll < 92) begin
          value = RADICAND_BITS'($urandom_range(16'hFF00, 16'hFFFF));
        end else begin
          value = RADICAND_BITS'($urandom_range(0, 1));
        end
        radicand_q.push_back(value);
      end
    end

    wait_until_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("tb_sqrt_rational_bounds_unit: done, clean");
    end else begin
      $display("tb_sqrt_rational_bounds_unit: done, errors");
    end
    $finish;
  end

endmodule

>>> sqrt_rational_bounds_unit.f
rtl/core/srb_pkg.sv
rtl/core/srb_if.sv
rtl/core/srb_mul.sv
rtl/core/srb_gcd.sv
rtl/core/srb_div.sv
rtl/core/sqrt_rational_bounds_unit.sv
verif/tb_sqrt_rational_bounds_unit.sv
